FILE: rtl/core/gnms_pkg.sv
// ----------------------------------------------------------------------------
// gnms_pkg: shared types and constants for non-maximum suppression
// Stream kinds, register indexes, direction codes and the queue entry that
// travels from the window front end to the compare back end.
// ----------------------------------------------------------------------------
package gnms_pkg;

  localparam int PIX_W      = 8;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 13;
  localparam int CFG_W      = 13;

  localparam logic [IMG_W_BITS-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] RESET_HEIGHT = 13'd480;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // Stored direction codes; anything above diagonal-up is kept as none
  localparam logic [2:0] DIR_HORZ      = 3'd0;
  localparam logic [2:0] DIR_DIAG_DOWN = 3'd1;
  localparam logic [2:0] DIR_VERT      = 3'd2;
  localparam logic [2:0] DIR_DIAG_UP   = 3'd3;
  localparam logic [2:0] DIR_NONE      = 3'd4;

  // One classified pixel waiting for its compare
  typedef struct packed {
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] n1;
    logic [PIX_W-1:0] n2;
    logic             interior;
    logic             last;
  } nms_entry_t;

endpackage

FILE: rtl/core/gradient_non_max_suppression.sv
// A result word passes the window stage register, the queue and the output
// register; results trail the pixel stream by image_width + 1 words.
// Throughput: one word per cycle unless the queue lacks room or a register
// write holds input, set by one line memory read and write per accepted word.
// A register write stalls input while the divider recomputes column and row.
// Reset clears control and window state; line memories hold no reset value.
// ----------------------------------------------------------------------------
// gradient_non_max_suppression: four-direction non-maximum suppression
// Raster pixel stream in, thinned magnitude stream out, with frame geometry
// set through a simple register write port.
// ----------------------------------------------------------------------------
module gradient_non_max_suppression import gnms_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // pixel input
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,   // [7:0] magnitude, [15:8] direction
  input  logic [0:0]       s_axis_tuser,   // [0] kind
  // result output
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] kept_value
  output logic             m_axis_tlast    // frame_end
);

  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
  localparam int SP_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

  function automatic logic [WID_W-1:0] sat_width(logic [IMG_W_BITS-1:0] raw);
    logic [WID_W-1:0] r;
    if (raw == '0) begin
      r = WID_W'(1);
    end else if (32'(raw) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(raw);
    end
    return r;
  endfunction

  function automatic logic [HGT_W-1:0] sat_height(logic [IMG_H_BITS-1:0] raw);
    logic [HGT_W-1:0] r;
    if (raw == '0) begin
      r = HGT_W'(1);
    end else if (32'(raw) > MAX_HEIGHT) begin
      r = HGT_W'(MAX_HEIGHT);
    end else begin
      r = HGT_W'(raw);
    end
    return r;
  endfunction

  logic [WID_W-1:0]      width_q;
  logic [HGT_W-1:0]      height_q;
  logic                  start_q;
  logic                  hold;

  logic                  div_busy, div_done;
  logic [SP_W-1:0]       div_quo, p_next;
  logic [WID_W-1:0]      div_rem;

  logic                  q_push, q_pop, q_valid;
  nms_entry_t            q_entry_in, q_entry_out;
  logic [FIFO_CNT_W-1:0] q_level;

  // Geometry registers, kept in saturated form
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sat_width(RESET_WIDTH);
      height_q <= sat_height(RESET_HEIGHT);
      start_q  <= 1'b0;
    end else begin
      start_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_IMAGE_WIDTH:  width_q  <= sat_width(cfg_data_i[IMG_W_BITS-1:0]);
          REG_IMAGE_HEIGHT: height_q <= sat_height(cfg_data_i[IMG_H_BITS-1:0]);
          default: ;
        endcase
      end
    end
  end

  // Hold input while the result position is being recomputed
  assign hold = cfg_we_i || start_q || div_busy || div_done;

  gnms_div #(
    .DIVD_W (SP_W),
    .DIVS_W (WID_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (p_next),
    .divisor_i  (width_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  gnms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .WID_W      (WID_W),
    .HGT_W      (HGT_W),
    .SP_W       (SP_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .width_i    (width_q),
    .height_i   (height_q),
    .hold_i     (hold),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .div_done_i (div_done),
    .div_quo_i  (div_quo),
    .div_rem_i  (div_rem),
    .p_next_o   (p_next),
    .q_level_i  (q_level),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry_in)
  );

  gnms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry_in),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry_out),
    .level_o (q_level)
  );

  gnms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

FILE: rtl/core/gnms_div.sv
// ----------------------------------------------------------------------------
// gnms_div: restoring divider for result position recompute
// Splits the pending result position into column and row after a register
// write changes the frame geometry. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module gnms_div #(
  parameter int DIVD_W = 23,
  parameter int DIVS_W = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVD_W-1:0] dividend_i,
  input  logic [DIVS_W-1:0] divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DIVD_W-1:0] quo_o,
  output logic [DIVS_W-1:0] rem_o
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DIVD_W-1:0] quo_q;
  logic [DIVS_W-1:0] rem_q;

  logic [DIVS_W:0]   cand, diff;
  logic              ge;
  logic [DIVS_W-1:0] rem_d;

  // Shift in the next dividend bit and try a subtract
  assign cand  = {rem_q, quo_q[DIVD_W-1]};
  assign ge    = cand >= {1'b0, divisor_i};
  assign diff  = cand - {1'b0, divisor_i};
  assign rem_d = ge ? diff[DIVS_W-1:0] : cand[DIVS_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIVD_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  // A restart on the done cycle discards the stale result
  assign busy_o = busy_q;
  assign done_o = done_q && !start_i;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem_q < divisor_i))
    else $error("divider remainder not below divisor");
`endif

endmodule

FILE: rtl/core/gnms_front.sv
// ----------------------------------------------------------------------------
// gnms_front: line buffers, 3x3 window and pixel classification
// Accepts words, tracks stream and result positions, reads and rewrites the
// line memory, shifts the window and queues centre and neighbor values.
// ----------------------------------------------------------------------------
module gnms_front import gnms_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int WID_W      = $clog2(MAX_WIDTH + 1),
  parameter int HGT_W      = $clog2(MAX_HEIGHT + 1),
  parameter int SP_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [WID_W-1:0]      width_i,
  input  logic [HGT_W-1:0]      height_i,
  input  logic                  hold_i,
  // input words
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [15:0]           s_tdata_i,   // [7:0] magnitude, [15:8] direction
  input  logic [0:0]            s_tuser_i,   // [0] kind
  // position recompute
  input  logic                  div_done_i,
  input  logic [SP_W-1:0]       div_quo_i,
  input  logic [WID_W-1:0]      div_rem_i,
  output logic [SP_W-1:0]       p_next_o,
  // queue
  input  logic [FIFO_CNT_W-1:0] q_level_i,
  output logic                  q_push_o,
  output nms_entry_t            q_entry_o
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LVL_W = FIFO_CNT_W + 1;

  typedef struct packed {
    logic [2:0]       dir;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] up;
  } line_word_t;

  line_word_t line_mem [MAX_WIDTH];

  // position state
  logic [COL_W-1:0] col_q;
  logic [SP_W-1:0]  sp_q;
  logic [COL_W-1:0] x_q;
  logic [SP_W-1:0]  y_q;

  // accept stage signals
  logic             accept, drop, act;
  logic [PIX_W-1:0] mag_a;
  logic [7:0]       dcode_a;
  logic [2:0]       dstore_a;
  logic [COL_W-1:0] c_a, col_d;
  logic             res_a, last_a, interior_a, x_last;

  // window stage registers
  logic             b_valid_q, b_res_q, b_interior_q, b_last_q;
  logic [COL_W-1:0] b_addr_q;
  logic [PIX_W-1:0] b_mag_q;
  logic [2:0]       b_dstore_q;
  logic             fwd_q;
  line_word_t       fwd_word_q, rd_q, rd_eff, wr_word;
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] nw    [9];
  logic [2:0]       held_q;
  logic [PIX_W-1:0] n1, n2;

  // Take a word only with room for it and the one in the window stage
  assign s_tready_o = !hold_i &&
    ((LVL_W'(q_level_i) + LVL_W'(b_valid_q)) < LVL_W'(FIFO_DEPTH));
  assign accept = s_tvalid_i && s_tready_o;
  assign drop   = (kind_e'(s_tuser_i) == KIND_FLUSH) && (sp_q == '0);
  assign act    = accept && !drop;

  assign mag_a    = (kind_e'(s_tuser_i) == KIND_FLUSH) ? '0 : s_tdata_i[7:0];
  assign dcode_a  = s_tdata_i[15:8];
  assign dstore_a = (dcode_a <= 8'(DIR_DIAG_UP)) ? dcode_a[2:0] : DIR_NONE;

  // Write column, wrapped against the current width
  assign c_a   = (32'(col_q) >= 32'(width_i)) ? '0 : col_q;
  assign col_d = (32'(c_a) + 32'd1 >= 32'(width_i)) ? '0 : c_a + COL_W'(1);

  // Classify the result position this word produces
  assign res_a      = sp_q >= SP_W'(width_i);
  assign x_last     = (32'(x_q) + 32'd1) == 32'(width_i);
  assign last_a     = res_a && ((32'(y_q) >= 32'(height_i)) ||
                      (((32'(y_q) + 32'd1) == 32'(height_i)) && x_last));
  assign interior_a = (x_q != '0) && (32'(x_q) + 32'd2 <= 32'(width_i)) &&
                      (y_q != '0) && (32'(y_q) + 32'd2 <= 32'(height_i));

  // Position of the next result for a recompute
  assign p_next_o = res_a ? (sp_q - SP_W'(width_i)) : '0;

  // Advance stream, column and result positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      sp_q  <= '0;
      x_q   <= '0;
      y_q   <= '0;
    end else if (div_done_i) begin
      x_q <= div_rem_i[COL_W-1:0];
      y_q <= div_quo_i;
    end else if (act) begin
      if (last_a) begin
        col_q <= '0;
        sp_q  <= '0;
        x_q   <= '0;
        y_q   <= '0;
      end else begin
        col_q <= col_d;
        sp_q  <= sp_q + SP_W'(1);
        if (res_a) begin
          if (x_last) begin
            x_q <= '0;
            y_q <= y_q + SP_W'(1);
          end else begin
            x_q <= x_q + COL_W'(1);
          end
        end
      end
    end
  end

  // Window stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
    end else begin
      b_valid_q <= act;
      if (act) begin
        fwd_q <= b_valid_q && (b_addr_q == c_a);
      end
    end
  end

  // Window stage payload
  always_ff @(posedge clk_i) begin
    if (act) begin
      b_addr_q     <= c_a;
      b_mag_q      <= mag_a;
      b_dstore_q   <= dstore_a;
      b_res_q      <= res_a;
      b_interior_q <= interior_a;
      b_last_q     <= last_a;
      fwd_word_q   <= wr_word;
    end
  end

  // Line memory: rewrite in the window stage, registered read on accept
  always_ff @(posedge clk_i) begin
    if (b_valid_q) begin
      line_mem[b_addr_q] <= wr_word;
    end
    if (act) begin
      rd_q <= line_mem[c_a];
    end
  end

  // Forward the word written by the previous item at the same column
  assign rd_eff  = fwd_q ? fwd_word_q : rd_q;
  assign wr_word = '{dir: b_dstore_q, mid: b_mag_q, up: rd_eff.mid};

  // Shifted window
  always_comb begin
    nw[0] = win_q[1];
    nw[1] = win_q[2];
    nw[2] = rd_eff.up;
    nw[3] = win_q[4];
    nw[4] = win_q[5];
    nw[5] = rd_eff.mid;
    nw[6] = win_q[7];
    nw[7] = win_q[8];
    nw[8] = b_mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
      held_q <= DIR_HORZ;
    end else if (b_valid_q) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= nw[i];
      end
      held_q <= rd_eff.dir;
    end
  end

  // Pick the neighbors across the gradient
  always_comb begin
    case (held_q)
      DIR_HORZ: begin
        n1 = nw[3];
        n2 = nw[5];
      end
      DIR_DIAG_DOWN: begin
        n1 = nw[0];
        n2 = nw[8];
      end
      DIR_VERT: begin
        n1 = nw[1];
        n2 = nw[7];
      end
      DIR_DIAG_UP: begin
        n1 = nw[2];
        n2 = nw[6];
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
  end

  assign q_push_o  = b_valid_q && b_res_q;
  assign q_entry_o = '{centre: nw[4], n1: n1, n2: n2,
                       interior: b_interior_q, last: b_last_q};

endmodule

FILE: rtl/core/gnms_fifo.sv
// ----------------------------------------------------------------------------
// gnms_fifo: short queue between front and back
// Holds classified pixels so the window stage and the output side stall
// independently.
// ----------------------------------------------------------------------------
module gnms_fifo import gnms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  nms_entry_t            entry_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output nms_entry_t            entry_o,
  output logic [FIFO_CNT_W-1:0] level_o
);

  nms_entry_t            buf_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + FIFO_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - FIFO_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= entry_i;
    end
  end

  assign valid_o = cnt_q != '0;
  assign entry_o = buf_q[rd_ptr_q];
  assign level_o = cnt_q;

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < FIFO_CNT_W'(FIFO_DEPTH)) || pop_i)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue pop while empty");
`endif

endmodule

FILE: rtl/core/gnms_back.sv
// ----------------------------------------------------------------------------
// gnms_back: compare and output register
// Keeps the centre only when it beats both neighbors on an interior pixel,
// and holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
module gnms_back import gnms_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  nms_entry_t       q_entry_i,
  output logic             q_pop_o,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [PIX_W-1:0] m_tdata_o,   // [7:0] kept_value
  output logic             m_tlast_o    // frame_end
);

  logic             m_valid_q, last_q;
  logic [PIX_W-1:0] kept_q, kept_d;

  assign q_pop_o = q_valid_i && (!m_valid_q || m_tready_i);

  // Strict local maximum across the gradient
  assign kept_d = (q_entry_i.interior &&
                   (q_entry_i.centre > q_entry_i.n1) &&
                   (q_entry_i.centre > q_entry_i.n2)) ? q_entry_i.centre : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kept_q <= kept_d;
      last_q <= q_entry_i.last;
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = kept_q;
  assign m_tlast_o  = last_q;

`ifndef SYNTHESIS
  a_pop_shows_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> m_tvalid_o)
    else $error("popped entry not presented");
`endif

endmodule
